// ----- design/spd_pkg.sv -----
// Package for the scalar-over-pixel divide block: widths, register indexes and the scale reset value.
// No dependencies.
`timescale 1ns / 1ps
package spd_pkg;
   localparam int SCALE_BITS = 48;
   localparam int FRAC_BITS  = 16;
   localparam int IDX_BITS   = 2;
   localparam int ELEM_W     = 16;
   localparam logic [IDX_BITS-1:0] REG_SCALE       = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_POLICY      = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_ELEM_SIGNED = 2'd2;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET   = 48'd65536;
endpackage

// ----- design/scalar_over_pixel_divide.sv -----
// Top level of the scalar-over-pixel divide block: a pipelined restoring divider.
// Depends on spd_pkg.
`timescale 1ns / 1ps
// Usage: requests enter on req_ (tdata holds the element, tlast the image end
// flag) and results leave on rsp_ (tdata the quotient, tlast the copied flag).
// Each result is scale / element, where scale is a signed fixed-point value with
// sixteen fraction bits. Saturate mode rounds to nearest even and clamps to the
// element range; wrap mode truncates toward zero and keeps the low bits.
// The csr_ port writes scale (index 0), policy (1) and elem_signed (2); write it
// only while the pipeline is empty.
// Throughput is one request per clock while the receiver does not stall. There are
// 32 quotient bit stages plus one input and one output stage.
// The quotient has at most 32 significant bits (scale magnitude over 2^16 over
// an element of at least one), so one divider stage per quotient bit sets the
// depth; each stage is one subtract and compare on the 48-bit remainder.
// Reset clears all valid bits and restores the registers to scale 1.0,
// saturate mode and unsigned elements. When the receiver stalls, the whole
// pipeline holds: every stage advances only while the output is free or taken,
// so nothing is lost or repeated.
module scalar_over_pixel_divide #(
   parameter int ELEM_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata, // element[15:0]
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [15:0] rsp_tdata, // quotient[15:0]
   output logic rsp_tlast,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [spd_pkg::IDX_BITS-1:0] csr_index,
   input  logic [spd_pkg::SCALE_BITS-1:0] csr_data
);
   import spd_pkg::*;
   localparam int QB = 32;
   localparam int EW = ELEM_BITS;
   localparam int DW = SCALE_BITS;

   function automatic logic [EW+15:0] res_ext(input logic [EW-1:0] v);
      res_ext = (EW+16)'(v);
   endfunction

   logic [SCALE_BITS-1:0] scale_ff;
   logic policy_ff, esigned_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         policy_ff <= 1'b0;
         esigned_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SCALE:       scale_ff <= csr_data;
            REG_POLICY:      policy_ff <= csr_data[0];
            REG_ELEM_SIGNED: esigned_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Input stage: magnitudes and sign.
   logic [EW-1:0] x_raw;
   logic [EW-1:0] x_mag_in;
   logic x_neg, s_neg, zero_in;
   logic [DW-1:0] s_mag_in;
   always_comb begin
      x_raw = EW'(req_tdata);
      x_neg = esigned_ff && x_raw[EW-1];
      x_mag_in = x_neg ? (~x_raw + 1'b1) : x_raw;
      s_neg = scale_ff[DW-1];
      s_mag_in = s_neg ? (~scale_ff + 1'b1) : scale_ff;
      zero_in = (s_mag_in[DW-1:FRAC_BITS] == '0) || (x_mag_in == '0);
   end

   logic [QB:0] v_ff;
   logic [DW-1:0] rem_ff [QB+1];
   logic [EW-1:0] div_ff [QB+1];
   logic [QB-1:0] q_ff [QB+1];
   logic neg_ff [QB+1];
   logic zero_ff [QB+1];
   logic last_ff [QB+1];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[QB-1:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= s_mag_in;
         div_ff[0] <= x_mag_in;
         q_ff[0] <= '0;
         neg_ff[0] <= s_neg ^ x_neg;
         zero_ff[0] <= zero_in;
         last_ff[0] <= req_tlast;
      end
   end

   // Stage k decides quotient bit QB-1-k against divisor << (FRAC_BITS + bit).
   for (genvar k = 0; k < QB; k++) begin : g_div
      localparam int SH = FRAC_BITS + QB - 1 - k;
      logic [DW+EW+QB:0] dsh;
      logic [DW+EW+QB:0] rw;
      logic take;
      assign dsh = (DW+EW+QB+1)'(div_ff[k]) << SH;
      assign rw = (DW+EW+QB+1)'(rem_ff[k]);
      assign take = rw >= dsh;
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1] <= take ? DW'(rw - dsh) : rem_ff[k];
            q_ff[k+1] <= q_ff[k] | (QB'(take) << (QB - 1 - k));
            div_ff[k+1] <= div_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            last_ff[k+1] <= last_ff[k];
         end
      end
   end

   // Output stage: round, clamp or wrap, apply sign, force the zero cases to zero.
   logic [DW+1:0] r2, dfull;
   logic [QB:0] qr, lim;
   logic [EW-1:0] res;
   logic [EW-1:0] qo_ff;
   logic lo_ff, vo_ff;
   always_comb begin
      r2 = {1'b0, rem_ff[QB], 1'b0};
      dfull = (DW+2)'(div_ff[QB]) << FRAC_BITS;
      qr = {1'b0, q_ff[QB]};
      if (r2 > dfull || (r2 == dfull && q_ff[QB][0])) qr = qr + 1'b1;
      if (neg_ff[QB]) lim = esigned_ff ? ((QB+1)'(1) << (EW-1)) : '0;
      else lim = esigned_ff ? (((QB+1)'(1) << (EW-1)) - 1'b1)
                            : (((QB+1)'(1) << EW) - 1'b1);
      if (policy_ff) qr = {1'b0, q_ff[QB]};
      else if (qr > lim) qr = lim;
      res = neg_ff[QB] ? EW'(~qr + 1'b1) : EW'(qr);
      if (zero_ff[QB]) res = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (adv) vo_ff <= v_ff[QB];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         qo_ff <= res;
         lo_ff <= last_ff[QB];
      end
   end
   assign rsp_tvalid = vo_ff;
   assign rsp_tdata = 16'(res_ext(qo_ff));
   assign rsp_tlast = lo_ff;

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("empty output blocks input");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      adv && v_ff[QB] && zero_ff[QB] |=> rsp_tdata == '0)
      else $error("zero case gave nonzero result");
`endif
endmodule

// ----- tb/sv/scalar_over_pixel_divide_tb.sv -----
// Testbench for the scalar-over-pixel divide block: directed and random requests,
// checked against a built-in quotient predictor. Depends on spd_pkg and the block.
`timescale 1ns / 1ps
module scalar_over_pixel_divide_tb;
   import spd_pkg::*;

   localparam int EB = 16;

   // One expected response: the quotient bits and the copied image end flag.
   typedef struct packed {
      logic [15:0] quotient;
      logic        last;
   } quot_type;

   // Predicts each quotient from the register copies and holds the expected
   // responses in arrival order.
   class quotient_board;
      logic [SCALE_BITS-1:0] scale_reg;
      logic                  wrap_mode;
      logic                  elem_is_signed;
      quot_type              pending[$];
      int                    errors;

      function void reset_regs();
         scale_reg      = SCALE_RESET;
         wrap_mode      = 1'b0;
         elem_is_signed = 1'b0;
      endfunction

      function void write_reg(logic [IDX_BITS-1:0] idx, logic [SCALE_BITS-1:0] val);
         case (idx)
            REG_SCALE:       scale_reg = val;
            REG_POLICY:      wrap_mode = val[0];
            REG_ELEM_SIGNED: elem_is_signed = val[0];
            default: ;
         endcase
      endfunction

      function logic [15:0] divide(logic [15:0] elem);
         logic [63:0] s_mag, x_mag, d, q, r, lim;
         logic        s_neg, x_neg, neg;
         s_neg = scale_reg[SCALE_BITS-1];
         x_neg = elem_is_signed && elem[EB-1];
         s_mag = 64'(scale_reg);
         if (s_neg) s_mag = (64'd1 << SCALE_BITS) - s_mag;
         x_mag = x_neg ? 64'(16'(-elem)) : 64'(elem);
         if (x_neg && elem == 16'h8000) x_mag = 64'h8000;
         if (s_mag < (64'd1 << FRAC_BITS) || x_mag == 0) return '0;
         d   = x_mag << FRAC_BITS;
         q   = s_mag / d;
         r   = s_mag % d;
         neg = s_neg != x_neg;
         if (wrap_mode) return neg ? 16'(-q) : 16'(q);
         // Round to nearest, ties to even, then clamp to the element range.
         if (2 * r > d || (2 * r == d && q[0])) q++;
         if (neg) lim = elem_is_signed ? 64'h8000 : 64'd0;
         else     lim = elem_is_signed ? 64'h7fff : 64'hffff;
         if (q > lim) q = lim;
         return neg ? 16'(-q) : 16'(q);
      endfunction

      function void note_request(logic [15:0] elem, logic last);
         quot_type e;
         e.quotient = divide(elem);
         e.last     = last;
         pending.insert(pending.size(), e);
      endfunction

      task check_response(logic [15:0] quotient, logic last);
         quot_type e;
         if (pending.size() == 0) begin
            report_error($sformatf("unexpected response %h", quotient));
            return;
         end
         e = pending.pop_front();
         if (quotient !== e.quotient)
            report_error($sformatf("quotient %h, expected %h", quotient, e.quotient));
         if (last !== e.last)
            report_error($sformatf("tlast %b, expected %b", last, e.last));
      endtask

      task report_error(string msg);
         errors++;
         $display("%0t ns: mismatch: %s", $time, msg);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;  // element[15:0]
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;       // quotient[15:0]
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [IDX_BITS-1:0]   csr_index = '0;
   logic [SCALE_BITS-1:0] csr_data = '0;

   quotient_board board = new();
   int  burst_left = 0;
   bit  stall_on = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   scalar_over_pixel_divide #(.ELEM_BITS(EB)) uut (.*);

   // The receiver stalls on its own pattern: periods of steady readiness
   // alternate with periods of random stalls.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tlast);
      if ($urandom_range(0, 99) == 0) stall_on <= ~stall_on;
      rsp_tready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
   end

   // Sends one request. The sender works in bursts with random gaps between them;
   // tvalid stays high across back-to-back requests of one burst.
   task automatic send(input logic [15:0] elem, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= elem;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_request(elem, last);
   endtask

   // Waits until every expected response has arrived, then writes a register.
   task automatic write_csr(input logic [IDX_BITS-1:0] idx,
                            input logic [SCALE_BITS-1:0] val);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (board.pending.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.write_reg(idx, val);
   endtask

   task automatic set_mode(input logic [SCALE_BITS-1:0] sc, input logic wrap,
                           input logic sgn);
      write_csr(REG_SCALE, sc);
      write_csr(REG_POLICY, {47'd0, wrap});
      write_csr(REG_ELEM_SIGNED, {47'd0, sgn});
   endtask

   // Picks a scale, in half the cases of moderate size so quotients land in range, with
   // the extremes and the below-one region now and then.
   function automatic logic [SCALE_BITS-1:0] pick_scale();
      logic [SCALE_BITS-1:0] v;
      case ($urandom_range(0, 5))
         0: v = 48'({$urandom, $urandom});
         1: v = 48'($urandom_range(0, 65535));
         2: v = $urandom_range(0, 1) ? 48'h7fff_ffff_ffff : 48'h8000_0000_0000;
         default: v = 48'($urandom_range(1, 1 << 14)) << $urandom_range(10, 30);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic logic [15:0] pick_elem();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 3));
         1: return -16'($urandom_range(0, 3));
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      board.reset_regs();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset settings first, then the corner settings.
      send(16'h0000, 1'b0);   // zero element
      send(16'h0001, 1'b1);
      send(16'hffff, 1'b0);
      set_mode(48'h7fff_ffff_ffff, 1'b0, 1'b1);  // largest scale, saturating
      send(16'h0001, 1'b0);
      send(16'h8000, 1'b1);
      send(16'h7fff, 1'b0);
      set_mode(48'h8000_0000_0000, 1'b1, 1'b1);  // most negative scale, wrapping
      send(16'h0001, 1'b0);
      send(16'hffff, 1'b1);
      send(16'h0003, 1'b0);
      set_mode(48'h0000_0000_ffff, 1'b0, 1'b0);  // just below one: all zero
      send(16'h0001, 1'b1);
      set_mode(-48'sd3 <<< 15, 1'b0, 1'b0);      // -1.5 unsigned: clamps to zero
      send(16'h0001, 1'b0);
      set_mode(48'd5 << 15, 1'b0, 1'b1);         // 2.5: tie cases round to even
      send(16'h0001, 1'b0);
      send(16'hffff, 1'b1);
      send(16'h0002, 1'b0);

      // Random part in phases of 32 requests with fresh settings.
      for (int ph = 0; ph < 40; ph++) begin
         set_mode(pick_scale(), 1'($urandom), 1'($urandom));
         repeat (32) send(pick_elem(), 1'($urandom_range(0, 7) == 0));
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
